>>> src/sha256_message_digest_macros.svh
// Assertion macros for the SHA-256 message digest block.
// Used by the port checker; no other dependencies.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// implication checked every clock while out of reset
`define SMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sha256_pkg.sv
// SHA-256 package: round constants, initial hash values, rotate-right function.
// No dependencies.
package sha256_pkg;
	typedef logic [31:0] word_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] POS_LEN = 6'd56;

	localparam word_t START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

>>> src/sha256_core.sv
// SHA-256 compression core: one round per cycle on a 16-word schedule window.
// Depends on sha256_pkg.
module sha256_core import sha256_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,       // start pulse
	input  logic       init,        // load initial hash values
	input  word_t      blk [16],
	output logic       busy,
	output word_t      hash [8]
);
	word_t w_q [16];
	word_t v_q [8];
	word_t h_q [8];
	logic [5:0] rnd_q;
	logic run_q, fin_q;
	word_t t1, t2, s0, s1, wn, e, a;

	always_comb begin
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = s1 + w_q[9] + s0 + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
			h_q <= START_H;
		end else begin
			fin_q <= 1'b0;
			if (init) begin
				h_q <= START_H;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= blk;
			v_q <= h_q;
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign busy = run_q | fin_q | start;
	assign hash = h_q;
endmodule

>>> src/sha256_message_digest.sv
// SHA-256 message digest top level: byte buffer, padding sequencer, output.
// Depends on sha256_pkg and sha256_core.
//
// channel | dir | tdata                  | tuser
// s_axis  | in  | [7:0] data_byte        | op
// m_axis  | out | [31:0] digest_word,    | -
//         |     | [34:32] word_index     | (tlast = last_word)
//
// An absorb byte is taken whenever s_axis is ready; the 64th byte of a block
// starts the shared round core (load, 64 rounds, fold, return to idle). A finish
// feeds pad bytes one a cycle, runs one or two blocks, then offers 8 words.
// Reset restores the initial hash values and zero bit count.
// Stalls on m_axis hold the current word; s_axis is not ready meanwhile.
module sha256_message_digest import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // digest_word, word_index
	output logic        m_axis_tlast    // last_word
);
	typedef enum logic [2:0] {ST_IN, ST_COMP, ST_PAD, ST_WAIT, ST_OUT} st_t;

	st_t st_q;
	logic [511:0] blk_q;
	logic [63:0] cnt_q, len_q;
	logic [2:0] idx_q;
	logic pad_q, init_q, tail_q;
	logic start_q;
	logic busy;
	word_t hash [8];
	word_t blk [16];
	logic [5:0] pos;
	logic wr;
	logic [7:0] wbyte;

	assign pos = cnt_q[8:3];

	always_comb begin
		for (int i = 0; i < 16; i++)
			blk[i] = blk_q[511 - 32*i -: 32];
		wr = 1'b0;
		wbyte = s_axis_tdata;
		if (st_q == ST_IN && s_axis_tvalid && !s_axis_tuser) wr = 1'b1;
		if (st_q == ST_PAD) begin
			wr = 1'b1;
			if (!pad_q) wbyte = PAD_MARK;
			else if (tail_q && pos >= POS_LEN)
				wbyte = len_q[8'd63 - {pos[2:0], 3'b000} -: 8];
			else wbyte = 8'h00;
		end
	end

	// bytes arrive in block order, so a shift register holds the block
	always_ff @(posedge clk) begin
		if (wr) blk_q <= {blk_q[503:0], wbyte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IN;
			cnt_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			pad_q <= 1'b0;
			init_q <= 1'b0;
			tail_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			init_q <= 1'b0;
			unique case (st_q)
				ST_IN: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser) begin
							len_q <= cnt_q;
							pad_q <= 1'b0;
							tail_q <= (pos < POS_LEN);
							st_q <= ST_PAD;
						end else begin
							cnt_q <= cnt_q + 64'd8;
							if (pos == 6'd63) begin
								start_q <= 1'b1;
								st_q <= ST_COMP;
							end
						end
					end
				end
				ST_PAD: begin
					pad_q <= 1'b1;
					cnt_q <= cnt_q + 64'd8;
					if (pos == 6'd63) begin
						start_q <= 1'b1;
						st_q <= ST_WAIT;
					end
				end
				ST_COMP: begin
					if (!busy) st_q <= ST_IN;
				end
				ST_WAIT: begin
					if (!busy) begin
						if (!tail_q) begin
							tail_q <= 1'b1;
							st_q <= ST_PAD;
						end else begin
							idx_q <= '0;
							st_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							cnt_q <= '0;
							init_q <= 1'b1;
							st_q <= ST_IN;
						end
					end
				end
				default: st_q <= ST_IN;
			endcase
		end
	end

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.init   (init_q),
		.blk    (blk),
		.busy   (busy),
		.hash   (hash)
	);

	assign s_axis_tready = (st_q == ST_IN);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {5'd0, idx_q, hash[idx_q]};
	assign m_axis_tlast = (idx_q == 3'd7);
endmodule

>>> src/sha256_message_digest_check.sv
// Port checker for sha256_message_digest, attached by bind.
// Depends on sha256_message_digest_macros.svh.
`include "sha256_message_digest_macros.svh"
module sha256_message_digest_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	logic [2:0] idx, idx_nx;
	logic out_wait, step_go;

	assign idx = m_axis_tdata[34:32];
	assign idx_nx = idx + 3'd1;
	assign out_wait = m_axis_tvalid && !m_axis_tready;
	assign step_go = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

	`SMD_ASSERT_IMP(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready, "ready during output")
	`SMD_ASSERT_IMP(a_last_idx, clk, arst_n, m_axis_tvalid, m_axis_tlast == (idx == 3'd7), "bad tlast")
	`SMD_ASSERT_NXT(a_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata), "not held")
	`SMD_ASSERT_NXT(a_idx_step, clk, arst_n, step_go, m_axis_tvalid && idx == $past(idx_nx), "index skip")
endmodule

bind sha256_message_digest sha256_message_digest_check u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
